[hw/rtl/aalr_pkg.sv]
// shared types and constants for the antialiased line rasterizer
package aalr_pkg;

    // fixed widths of the result fields and the gradient datapath
    localparam int PX_W      = 14;
    localparam int WT_W      = 8;
    localparam int GRAD_FRAC = 16;
    localparam int SLOPE_W   = GRAD_FRAC + 2;
    localparam int QUO_W     = GRAD_FRAC + 1;

    // command codes carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // sequencer states
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_SWAP  = 11'b000_0000_0010,
        ST_ORDER = 11'b000_0000_0100,
        ST_DIFF  = 11'b000_0000_1000,
        ST_DIV   = 11'b000_0001_0000,
        ST_MUL0  = 11'b000_0010_0000,
        ST_END0  = 11'b000_0100_0000,
        ST_MUL1  = 11'b000_1000_0000,
        ST_END1  = 11'b001_0000_0000,
        ST_STEP  = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } t_state;

    // one result word
    typedef struct packed {
        logic            valid;
        logic [PX_W-1:0] near_x;
        logic [PX_W-1:0] near_y;
        logic [WT_W-1:0] near_w;
        logic [PX_W-1:0] far_x;
        logic [PX_W-1:0] far_y;
        logic [WT_W-1:0] far_w;
        logic            done;
    } t_px_pair;

endpackage

[hw/rtl/antialiased_line_rasterizer_top.sv]
// antialiased line rasterizer: sequencer, divider, shared multiplier, output register
//
// Input channel (s side): one word per command. tuser is the command (start or step),
// tdata holds start_x, start_y, end_x, end_y (16 bits each, unsigned fixed point),
// used on start only. Output channel (m side): exactly one word per command.
// tuser is valid_res, tlast is line_done, tdata holds the pixel pair.
// A start runs two compare/swap states (swap, order), one setup state, the gradient divider
// (slope set to one when dx is zero, else one quotient bit per cycle), then two
// multiply/add passes through one shared multiplier for the endpoint minor values;
// the first column is registered after the second pass and then offered.
// A step word computes its column in the step state and the registered result is then
// offered. A step with no line in progress returns a word with valid_res low and all
// fields zero. One command is in flight at a time: tready is high only when the
// sequencer is idle, and the result word sits in the output register until the
// receiver takes it; a stall on the m side holds the word and keeps tready low.
// The next command can be taken in the cycle after the result is taken.
// Synchronous reset puts the sequencer in idle with no line in progress and no
// result pending.
module antialiased_line_rasterizer_top #(
    parameter int COORD_INT_BITS  = 12,
    parameter int COORD_FRAC_BITS = 4,
    parameter int WEIGHT_BITS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [63:0] i_s_tdata,
    // command
    input  logic [0:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // near_px_x, near_px_y, near_weight, far_px_x, far_px_y, far_weight
    output logic [71:0] o_m_tdata,
    // valid_res
    output logic [0:0]  o_m_tuser,
    output logic        o_m_tlast
);

    localparam int CW    = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int CF    = COORD_FRAC_BITS;
    localparam int JW    = COORD_INT_BITS + 1;
    localparam int MW    = COORD_INT_BITS + 19;
    localparam int DW    = COORD_FRAC_BITS + 2;
    localparam int SW    = aalr_pkg::SLOPE_W;
    localparam int QW    = aalr_pkg::QUO_W;
    localparam int PW    = SW + DW;
    localparam int HALF  = (1 << COORD_FRAC_BITS) >> 1;
    localparam logic [15:0] CMASK = 16'((1 << CW) - 1);

    // pixel pair from a major position and a minor value
    function automatic aalr_pkg::t_px_pair emit_pair(
        input logic [JW-1:0]        major,
        input logic signed [MW-1:0] minor,
        input logic                 done,
        input logic                 steep
    );
        logic signed [MW-17:0]                 fl;
        logic [WEIGHT_BITS-1:0]                fr;
        logic [WEIGHT_BITS-1:0]                frn;
        logic [aalr_pkg::PX_W-1:0]             m0;
        logic [aalr_pkg::PX_W-1:0]             m1;
        logic [aalr_pkg::PX_W-1:0]             mj;
        aalr_pkg::t_px_pair                    p;
        fl  = (MW-16)'(minor >>> aalr_pkg::GRAD_FRAC);
        fr  = minor[aalr_pkg::GRAD_FRAC-1 -: WEIGHT_BITS];
        frn = ~fr;
        m0  = aalr_pkg::PX_W'(fl);
        m1  = m0 + aalr_pkg::PX_W'(1);
        mj  = aalr_pkg::PX_W'(major);
        p.valid  = 1'b1;
        p.near_x = steep ? m0 : mj;
        p.near_y = steep ? mj : m0;
        p.far_x  = steep ? m1 : mj;
        p.far_y  = steep ? mj : m1;
        p.near_w = aalr_pkg::WT_W'(frn);
        p.far_w  = aalr_pkg::WT_W'(fr);
        p.done   = done;
        return p;
    endfunction

    aalr_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic                 r_steep, n_steep;
    logic                 r_neg, n_neg;
    logic [CW-1:0]        r_dx, n_dx;
    logic [CW:0]          r_rem, n_rem;
    logic [QW-1:0]        r_quo, n_quo;
    logic [4:0]           r_cnt, n_cnt;
    logic signed [SW-1:0] r_slope, n_slope;
    logic [JW-1:0]        r_pos, n_pos, r_last, n_last;
    logic signed [MW-1:0] r_accum, n_accum, r_at_last, n_at_last;
    logic signed [PW-1:0] r_prod, n_prod;
    logic                 r_active, n_active;
    aalr_pkg::t_px_pair   r_res, n_res;

    // masked input coordinates
    logic [CW-1:0] in_x0, in_y0, in_x1, in_y1;
    assign in_x0 = CW'(i_s_tdata[15:0]  & CMASK);
    assign in_y0 = CW'(i_s_tdata[31:16] & CMASK);
    assign in_x1 = CW'(i_s_tdata[47:32] & CMASK);
    assign in_y1 = CW'(i_s_tdata[63:48] & CMASK);

    // steepness test
    logic signed [CW:0] sdx, sdy;
    logic [CW:0]        adx, ady;
    assign sdx = $signed({1'b0, r_x1}) - $signed({1'b0, r_x0});
    assign sdy = $signed({1'b0, r_y1}) - $signed({1'b0, r_y0});
    assign adx = sdx[CW] ? $unsigned(-sdx) : $unsigned(sdx);
    assign ady = sdy[CW] ? $unsigned(-sdy) : $unsigned(sdy);

    // major axis rounding, half rounds up
    logic [CW:0] rnd0, rnd1;
    assign rnd0 = {1'b0, r_x0} + (CW+1)'(HALF);
    assign rnd1 = {1'b0, r_x1} + (CW+1)'(HALF);

    // restoring divider step
    logic          rem_ge;
    logic [CW:0]   rem_sub;
    logic [QW-1:0] quo_nx;
    assign rem_ge  = r_rem >= {1'b0, r_dx};
    assign rem_sub = rem_ge ? (r_rem - {1'b0, r_dx}) : r_rem;
    assign quo_nx  = {r_quo[QW-2:0], rem_ge};

    // shared multiplier: gradient times endpoint offset
    logic [CW-1:0]        mul_x;
    logic [JW-1:0]        mul_r;
    logic signed [CW+1:0] dfull;
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod_c;
    assign mul_x  = (r_state == aalr_pkg::ST_MUL1) ? r_x1 : r_x0;
    assign mul_r  = (r_state == aalr_pkg::ST_MUL1) ? r_last : r_pos;
    assign dfull  = $signed((CW+2)'(mul_r) << CF) - $signed((CW+2)'(mul_x));
    assign diff   = DW'(dfull);
    assign prod_c = r_slope * diff;

    // endpoint minor value
    logic [CW-1:0]        y_sel;
    logic signed [MW-1:0] ybase, minor_end;
    assign y_sel     = (r_state == aalr_pkg::ST_END1) ? r_y1 : r_y0;
    assign ybase     = $signed(MW'(y_sel) << (aalr_pkg::GRAD_FRAC - CF));
    assign minor_end = ybase + MW'(r_prod >>> CF);

    // column advance
    logic [JW:0] pos_inc;
    logic        more;
    assign pos_inc = (JW+1)'(r_pos) + (JW+1)'(1);
    assign more    = pos_inc < (JW+1)'(r_last);

    // sequencer and datapath next state
    always_comb begin
        n_state   = r_state;
        n_x0      = r_x0;
        n_y0      = r_y0;
        n_x1      = r_x1;
        n_y1      = r_y1;
        n_steep   = r_steep;
        n_neg     = r_neg;
        n_dx      = r_dx;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_slope   = r_slope;
        n_pos     = r_pos;
        n_last    = r_last;
        n_accum   = r_accum;
        n_at_last = r_at_last;
        n_prod    = r_prod;
        n_active  = r_active;
        n_res     = r_res;
        unique case (r_state)
            aalr_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser[0] == aalr_pkg::CMD_START) begin
                        n_x0    = in_x0;
                        n_y0    = in_y0;
                        n_x1    = in_x1;
                        n_y1    = in_y1;
                        n_state = aalr_pkg::ST_SWAP;
                    end else begin
                        n_state = aalr_pkg::ST_STEP;
                    end
                end
            end
            aalr_pkg::ST_SWAP: begin
                n_steep = ady > adx;
                if (ady > adx) begin
                    n_x0 = r_y0;
                    n_y0 = r_x0;
                    n_x1 = r_y1;
                    n_y1 = r_x1;
                end
                n_state = aalr_pkg::ST_ORDER;
            end
            aalr_pkg::ST_ORDER: begin
                if (r_x0 > r_x1) begin
                    n_x0 = r_x1;
                    n_y0 = r_y1;
                    n_x1 = r_x0;
                    n_y1 = r_y0;
                end
                n_state = aalr_pkg::ST_DIFF;
            end
            aalr_pkg::ST_DIFF: begin
                n_dx    = r_x1 - r_x0;
                n_neg   = sdy[CW];
                n_rem   = ady;
                n_quo   = '0;
                n_cnt   = '0;
                n_pos   = rnd0[CW:CF];
                n_last  = rnd1[CW:CF];
                n_state = aalr_pkg::ST_DIV;
            end
            aalr_pkg::ST_DIV: begin
                if (r_dx == '0) begin
                    n_slope = SW'(1 << aalr_pkg::GRAD_FRAC);
                    n_state = aalr_pkg::ST_MUL0;
                end else begin
                    n_rem = {rem_sub[CW-1:0], 1'b0};
                    n_quo = quo_nx;
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == 5'(QW - 1)) begin
                        n_slope = r_neg ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
                        n_state = aalr_pkg::ST_MUL0;
                    end
                end
            end
            aalr_pkg::ST_MUL0: begin
                n_prod  = prod_c;
                n_state = aalr_pkg::ST_END0;
            end
            aalr_pkg::ST_END0: begin
                n_accum = minor_end;
                n_state = aalr_pkg::ST_MUL1;
            end
            aalr_pkg::ST_MUL1: begin
                n_prod  = prod_c;
                n_state = aalr_pkg::ST_END1;
            end
            aalr_pkg::ST_END1: begin
                n_at_last = minor_end;
                n_res     = emit_pair(r_pos, r_accum, 1'b0, r_steep);
                n_accum   = r_accum + MW'(r_slope);
                n_active  = 1'b1;
                n_state   = aalr_pkg::ST_OUT;
            end
            aalr_pkg::ST_STEP: begin
                if (!r_active) begin
                    n_res = '0;
                end else if (more) begin
                    n_pos   = pos_inc[JW-1:0];
                    n_res   = emit_pair(pos_inc[JW-1:0], r_accum, 1'b0, r_steep);
                    n_accum = r_accum + MW'(r_slope);
                end else begin
                    n_pos    = r_last;
                    n_res    = emit_pair(r_last, r_at_last, 1'b1, r_steep);
                    n_active = 1'b0;
                end
                n_state = aalr_pkg::ST_OUT;
            end
            aalr_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_state = aalr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aalr_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= aalr_pkg::ST_IDLE;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x0      <= n_x0;
        r_y0      <= n_y0;
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_steep   <= n_steep;
        r_neg     <= n_neg;
        r_dx      <= n_dx;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_slope   <= n_slope;
        r_pos     <= n_pos;
        r_last    <= n_last;
        r_accum   <= n_accum;
        r_at_last <= n_at_last;
        r_prod    <= n_prod;
        r_res     <= n_res;
    end

    // ports
    assign o_s_tready = (r_state == aalr_pkg::ST_IDLE);
    assign o_m_tvalid = (r_state == aalr_pkg::ST_OUT);
    assign o_m_tdata  = {r_res.far_w, r_res.far_y, r_res.far_x,
                         r_res.near_w, r_res.near_y, r_res.near_x};
    assign o_m_tuser  = r_res.valid;
    assign o_m_tlast  = r_res.done;

endmodule

[tb/tb_antialiased_line_rasterizer_top.sv]
// self-checking testbench for the antialiased line rasterizer top level
`timescale 1ns / 1ps

module tb_antialiased_line_rasterizer_top;

    localparam int CFRAC     = 4;
    localparam int N_DIR     = 24;
    localparam int N_RAND    = 1750;
    localparam int IDLE_PCT  = 22;
    localparam aalr_pkg::t_px_pair IDLE_PAIR = '0;

    // one command word, with an optional typed-in expectation
    typedef struct {
        logic               cmd;
        logic [63:0]        data;
        bit                 chk;
        aalr_pkg::t_px_pair e;
    } t_cmd_word;

    typedef struct {
        logic               cmd;
        int                 sx;
        int                 sy;
        int                 ex;
        int                 ey;
        bit                 chk;
        aalr_pkg::t_px_pair e;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [63:0] s_data = '0;
    logic [0:0]  s_user = aalr_pkg::CMD_STEP;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [71:0] m_data;
    logic [0:0]  m_user;
    logic        m_last;

    t_cmd_word          stim [$];
    aalr_pkg::t_px_pair pair_exp [$];
    t_dir_row           dir_tab [N_DIR];
    int                 n_sent = 0;
    int                 n_err = 0;

    // line tracker state
    bit          ln_active = 1'b0;
    bit          ln_steep = 1'b0;
    longint      ln_pos = 0;
    longint      ln_last = 0;
    longint      ln_accum = 0;
    longint      ln_slope = 0;
    longint      ln_at_last = 0;

    wire calm = (n_sent >= N_DIR + 300) && (n_sent < N_DIR + 700);

    antialiased_line_rasterizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user),
        .o_m_tlast  (m_last)
    );

    always #5 i_clk = ~i_clk;

    // minor value in Q.16 at the rounded major position of an endpoint
    function automatic longint endpoint_minor(input longint x, input longint y,
                                              input longint xr);
        longint diff;
        diff = (xr <<< CFRAC) - x;
        return y * (64'sd1 <<< (aalr_pkg::GRAD_FRAC - CFRAC))
               + ((ln_slope * diff) >>> CFRAC);
    endfunction

    // pixel pair for one column
    function automatic aalr_pkg::t_px_pair pixel_pair(input longint major,
                                                      input longint minor,
                                                      input bit done);
        aalr_pkg::t_px_pair r;
        logic [63:0]        fl;
        logic [63:0]        fl1;
        logic [63:0]        mj;
        logic [63:0]        mn;
        mn  = minor;
        fl  = minor >>> aalr_pkg::GRAD_FRAC;
        fl1 = (minor >>> aalr_pkg::GRAD_FRAC) + 1;
        mj  = major;
        r.valid = 1'b1;
        if (ln_steep) begin
            r.near_x = fl[aalr_pkg::PX_W-1:0];
            r.near_y = mj[aalr_pkg::PX_W-1:0];
            r.far_x  = fl1[aalr_pkg::PX_W-1:0];
            r.far_y  = mj[aalr_pkg::PX_W-1:0];
        end else begin
            r.near_x = mj[aalr_pkg::PX_W-1:0];
            r.near_y = fl[aalr_pkg::PX_W-1:0];
            r.far_x  = mj[aalr_pkg::PX_W-1:0];
            r.far_y  = fl1[aalr_pkg::PX_W-1:0];
        end
        r.far_w  = mn[15:8];
        r.near_w = ~mn[15:8];
        r.done   = done;
        return r;
    endfunction

    // advance the line tracker by one command and return the column it yields
    function automatic aalr_pkg::t_px_pair advance_line(input logic cmd,
                                                        input logic [63:0] d);
        aalr_pkg::t_px_pair r;
        longint             x0, y0, x1, y1, t, dx, dy, adx, ady;
        r  = IDLE_PAIR;
        x0 = d[15:0];
        y0 = d[31:16];
        x1 = d[47:32];
        y1 = d[63:48];
        if (cmd == aalr_pkg::CMD_START) begin
            adx = (x1 > x0) ? x1 - x0 : x0 - x1;
            ady = (y1 > y0) ? y1 - y0 : y0 - y1;
            ln_steep = ady > adx;
            if (ln_steep) begin
                t = x0; x0 = y0; y0 = t;
                t = x1; x1 = y1; y1 = t;
            end
            if (x0 > x1) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dx = x1 - x0;
            dy = y1 - y0;
            ln_slope   = (dx == 0) ? (64'sd1 <<< aalr_pkg::GRAD_FRAC)
                                   : (dy * (64'sd1 <<< aalr_pkg::GRAD_FRAC)) / dx;
            ln_pos     = (x0 + (1 << (CFRAC - 1))) >>> CFRAC;
            ln_last    = (x1 + (1 << (CFRAC - 1))) >>> CFRAC;
            ln_accum   = endpoint_minor(x0, y0, ln_pos);
            ln_at_last = endpoint_minor(x1, y1, ln_last);
            r = pixel_pair(ln_pos, ln_accum, 1'b0);
            ln_accum  += ln_slope;
            ln_active  = 1'b1;
        end else if (ln_active) begin
            if (ln_pos + 1 < ln_last) begin
                ln_pos += 1;
                r = pixel_pair(ln_pos, ln_accum, 1'b0);
                ln_accum += ln_slope;
            end else begin
                ln_pos = ln_last;
                r = pixel_pair(ln_last, ln_at_last, 1'b1);
                ln_active = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic push_word(input logic cmd, input int sx, input int sy, input int ex,
                             input int ey, input bit chk, input aalr_pkg::t_px_pair e);
        t_cmd_word w;
        w.cmd  = cmd;
        w.data = {ey[15:0], ex[15:0], sy[15:0], sx[15:0]};
        w.chk  = chk;
        w.e    = e;
        stim = {stim, w};
    endtask

    task automatic check_field(input string fname, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, fname, want, got);
            n_err++;
        end
    endtask

    // sender: offer words, feed the tracker on each accepted word
    always @(posedge i_clk) begin : drive_words
        int                 nxt;
        aalr_pkg::t_px_pair pred;
        nxt = n_sent;
        if (rst_n && s_valid && s_ready) begin
            pred = advance_line(s_user[0], s_data);
            if (stim[nxt].chk) begin
                pred = stim[nxt].e;
            end
            pair_exp = {pair_exp, pred};
            nxt++;
            n_sent = nxt;
        end
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (nxt < stim.size()
                && !((nxt == N_DIR || nxt == N_DIR + 900) && pair_exp.size() != 0)
                && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_data  <= stim[nxt].data;
                s_user  <= stim[nxt].cmd;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, compare each taken word with the oldest expectation
    always @(posedge i_clk) begin : check_words
        aalr_pkg::t_px_pair want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pair_exp.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none actual 0x%0h",
                             $time, m_data);
                    n_err++;
                end else begin
                    want = pair_exp.pop_front();
                    check_field("valid_res", want.valid, m_user[0]);
                    check_field("near_px_x", want.near_x, m_data[13:0]);
                    check_field("near_px_y", want.near_y, m_data[27:14]);
                    check_field("near_weight", want.near_w, m_data[35:28]);
                    check_field("far_px_x", want.far_x, m_data[49:36]);
                    check_field("far_px_y", want.far_y, m_data[63:50]);
                    check_field("far_weight", want.far_w, m_data[71:64]);
                    check_field("line_done", want.done, m_last);
                end
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // stimulus build, reset, end of run
    initial begin : run_lines
        int     kind, nsteps, span, j;
        int     sx, sy, ex, ey, dmaj, dmin, m0, m1;
        bit     steep;

        // directed part: idle step, degenerate lines, extremes, octants, restart
        dir_tab = '{
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, IDLE_PAIR},
            '{aalr_pkg::CMD_START, 0, 0, 0, 0, 1'b1,
              '{1'b1, 14'd0, 14'd0, 8'd255, 14'd0, 14'd1, 8'd0, 1'b0}},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1,
              '{1'b1, 14'd0, 14'd0, 8'd255, 14'd0, 14'd1, 8'd0, 1'b1}},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, IDLE_PAIR},
            '{aalr_pkg::CMD_START, 65535, 65535, 65535, 65535, 1'b1,
              '{1'b1, 14'd4096, 14'd4096, 8'd255, 14'd4096, 14'd4097, 8'd0, 1'b0}},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1,
              '{1'b1, 14'd4096, 14'd4096, 8'd255, 14'd4096, 14'd4097, 8'd0, 1'b1}},
            '{aalr_pkg::CMD_START, 16, 16, 160, 48, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_START, 32, 0, 48, 400, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_START, 0, 800, 800, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_START, 800, 0, 0, 800, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_START, 7, 0, 400, 300, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_START, 8, 8, 40, 40, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_START, 0, 65535, 65535, 0, 1'b0, IDLE_PAIR},
            '{aalr_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, IDLE_PAIR}
        };
        foreach (dir_tab[i])
            push_word(dir_tab[i].cmd, dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex,
                      dir_tab[i].ey, dir_tab[i].chk, dir_tab[i].e);

        // random part: mostly whole short lines, some cut short, some noise
        while (stim.size() < N_DIR + N_RAND) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                // stray step with random payload
                push_word(aalr_pkg::CMD_STEP, $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(65535), 1'b0, IDLE_PAIR);
            end else if (kind < 15) begin
                // arbitrary endpoints, abandoned after a few columns
                push_word(aalr_pkg::CMD_START, $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(65535), 1'b0, IDLE_PAIR);
                nsteps = $urandom_range(1, 30);
                for (j = 0; j < nsteps; j++)
                    push_word(aalr_pkg::CMD_STEP, $urandom_range(65535), 0, 0,
                              $urandom_range(65535), 1'b0, IDLE_PAIR);
            end else begin
                sx    = $urandom_range(65535);
                sy    = $urandom_range(65535);
                dmaj  = $urandom_range(0, ($urandom_range(9) == 0) ? 1024 : 192);
                dmin  = $urandom_range(0, dmaj);
                steep = $urandom_range(1);
                if ($urandom_range(1)) dmaj = -dmaj;
                if ($urandom_range(1)) dmin = -dmin;
                ex = sx + (steep ? dmin : dmaj);
                ey = sy + (steep ? dmaj : dmin);
                ex = (ex < 0) ? 0 : (ex > 65535) ? 65535 : ex;
                ey = (ey < 0) ? 0 : (ey > 65535) ? 65535 : ey;
                push_word(aalr_pkg::CMD_START, sx, sy, ex, ey, 1'b0, IDLE_PAIR);
                // columns left after the first one
                steep = ((ey > sy) ? ey - sy : sy - ey) > ((ex > sx) ? ex - sx : sx - ex);
                m0 = ((steep ? sy : sx) + 8) >>> CFRAC;
                m1 = ((steep ? ey : ex) + 8) >>> CFRAC;
                span = (m1 > m0) ? m1 - m0 : m0 - m1;
                nsteps = (span < 1) ? 1 : span;
                kind = $urandom_range(99);
                if (kind < 10)
                    nsteps = $urandom_range(0, nsteps - 1);
                else if (kind < 20)
                    nsteps += $urandom_range(1, 3);
                for (j = 0; j < nsteps; j++)
                    push_word(aalr_pkg::CMD_STEP, $urandom_range(65535), $urandom_range(65535),
                              $urandom_range(65535), $urandom_range(65535), 1'b0, IDLE_PAIR);
            end
        end

        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        wait (n_sent == stim.size());
        wait (pair_exp.size() == 0);
        repeat (60) @(posedge i_clk);
        if (pair_exp.size() != 0) begin
            $display("%0t ns: %0d expected words never arrived", $time, pair_exp.size());
            n_err++;
        end
        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
